>>> src/psl_pkg.sv
package psl_pkg;

    localparam int LED_SLOTS = 8;

    localparam logic [7:0] DONE_MAX = 8'hFF;

    // request kinds carried in the input tuser
    typedef enum logic [1:0] {
        REQ_TICK       = 2'd0,
        REQ_WRITE      = 2'd1,
        REQ_REMOVE     = 2'd2,
        REQ_SET_ACTIVE = 2'd3
    } req_t;

    // one table entry as held in the entry memory
    typedef struct packed {
        logic [7:0]  prio;
        logic [2:0]  color;
        logic [15:0] period;
        logic [7:0]  limit;
        logic [7:0]  done;
        logic [31:0] order;
    } entry_t;

    // picker control from the sequencer
    typedef struct packed {
        logic clear;
        logic cand_valid;
    } pick_ctl_t;

endpackage

>>> src/psl_entry_mem.sv
module psl_entry_mem #(
    parameter int DEPTH = psl_pkg::LED_SLOTS,
    parameter int AW    = $clog2(psl_pkg::LED_SLOTS)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  psl_pkg::entry_t  wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output psl_pkg::entry_t  rd_data
);
    import psl_pkg::*;

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> src/psl_picker.sv
module psl_picker #(
    parameter int SLOT_W = $clog2(psl_pkg::LED_SLOTS)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  psl_pkg::pick_ctl_t ctl,
    input  psl_pkg::entry_t    cand,
    input  logic [SLOT_W-1:0]  cand_idx,
    output logic               found,
    output logic [SLOT_W-1:0]  best_idx,
    output psl_pkg::entry_t    best
);
    import psl_pkg::*;

    logic              found_reg;
    logic              found_next;
    logic [SLOT_W-1:0] idx_reg;
    logic [SLOT_W-1:0] idx_next;
    entry_t            best_reg;
    entry_t            best_next;
    logic              wins;

    // strict compare: on a full tie the earlier (lower) slot keeps its place
    assign wins = !found_reg ||
                  (cand.prio > best_reg.prio) ||
                  ((cand.prio == best_reg.prio) && (cand.order > best_reg.order));

    always_comb
    begin
        found_next = found_reg;
        idx_next   = idx_reg;
        best_next  = best_reg;
        if (ctl.clear)
        begin
            found_next = 1'b0;
        end
        else if (ctl.cand_valid && wins)
        begin
            found_next = 1'b1;
            idx_next   = cand_idx;
            best_next  = cand;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        best_reg <= best_next;
    end

    assign found    = found_reg;
    assign best_idx = idx_reg;
    assign best     = best_reg;

endmodule

>>> src/priority_status_led_blinker.sv
// Priority status LED blinker.
// Requests arrive on s_axis with the kind in tuser: a one-millisecond tick,
// a write of a table entry, a remove, or a change of an entry's active flag.
// Every request gives exactly one result on the m_axis stream: the RGB pin
// levels, whether an entry is shown and which slot. Pins and shown slot
// change on ticks only.
// The entry table sits in a synchronous memory; valid and active flags are
// flip-flops. A tick scans the memory one slot a cycle to find the shown
// entry, then updates the blink phase and, when the shown entry blinks with
// a limit, writes back its blink count. A tick passes ST_SCAN, ST_APPLY,
// ST_COUNT (only for that case) and ST_OUT; other requests go straight to
// ST_OUT. The scan through the single memory read port sets the pace of a
// tick. ST_OUT loads the result register once the output is free; only one
// request is taken at a time.
// One result register parts the two sides: a new request is taken
// while the previous result waits; a stalled receiver holds the result and
// the block stops once the next result is ready.
// cfg_wr_en/cfg_wr_data write led_off_level, used from the next tick on.
// Reset clears all flags, clocks and the blink state; outputs read zero and
// no result is pending. No clearing pass is needed.
module priority_status_led_blinker #(
    parameter int SLOTS = psl_pkg::LED_SLOTS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,     // led_off_level
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [1:0] req_type
    input  logic [1:0]  s_axis_tuser,
    // [2:0] slot, [10:3] priority_req, [13:11] color, [29:14] blink_period,
    // [37:30] blink_limit, [38] active_flag
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] red_level, [1] green_level, [2] blue_level, [3] shown_valid,
    // [6:4] shown_slot
    output logic [15:0] m_axis_tdata
);
    import psl_pkg::*;

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = SLOT_W + 1;
    localparam logic [CNT_W-1:0] SLOT_NONE = CNT_W'(SLOTS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY,
        ST_COUNT,
        ST_OUT
    } state_t;

    state_t            state_reg;
    logic              off_level_reg;
    logic [SLOTS-1:0]  valid_reg;
    logic [SLOTS-1:0]  active_reg;
    logic [31:0]       add_cnt_reg;
    logic [31:0]       ms_clock_reg;
    logic [31:0]       last_toggle_reg;
    logic              blink_phase_reg;
    logic              prev_phase_reg;
    logic [CNT_W-1:0]  last_shown_reg;
    logic [CNT_W-1:0]  scan_cnt_reg;
    logic [2:0]        pins_reg;
    logic              shown_valid_reg;
    logic [2:0]        shown_slot_reg;
    logic              m_valid_reg;
    logic [15:0]       m_data_reg;

    // request fields
    req_t              req_type;
    logic [2:0]        req_slot;
    logic [SLOT_W-1:0] slot_idx;
    logic              in_range;
    logic              accept;
    entry_t            new_entry;

    // memory ports
    logic              mem_wr_en;
    logic [SLOT_W-1:0] mem_wr_addr;
    entry_t            mem_wr_data;
    logic              mem_rd_en;
    entry_t            mem_rd_data;

    // picker
    pick_ctl_t         pick_ctl;
    logic [SLOT_W-1:0] cand_idx;
    logic              best_found;
    logic [SLOT_W-1:0] best_idx;
    entry_t            best;

    // tick evaluation
    logic              phase0;
    logic              show_on;
    logic [31:0]       elapsed;
    logic              toggle;
    logic              phase1;
    logic [2:0]        pins_next;
    logic              fall;
    logic [7:0]        done_next;
    entry_t            wb_entry;
    logic              out_free;

    assign req_type  = req_t'(s_axis_tuser);
    assign req_slot  = s_axis_tdata[2:0];
    assign slot_idx  = SLOT_W'(req_slot);
    assign in_range  = ({29'd0, req_slot} < 32'(SLOTS));
    assign accept    = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        new_entry.prio   = s_axis_tdata[10:3];
        new_entry.color  = s_axis_tdata[13:11];
        new_entry.period = s_axis_tdata[29:14];
        new_entry.limit  = s_axis_tdata[37:30];
        new_entry.done   = 8'd0;
        new_entry.order  = add_cnt_reg;
    end

    // scan: read slot n at count n, judge it in the next cycle
    assign mem_rd_en = (state_reg == ST_SCAN) && (scan_cnt_reg != SLOT_NONE);
    assign cand_idx  = SLOT_W'(scan_cnt_reg - CNT_W'(1));

    always_comb
    begin
        pick_ctl.clear      = accept && (req_type == REQ_TICK);
        pick_ctl.cand_valid = (state_reg == ST_SCAN) && (scan_cnt_reg != '0) &&
                              valid_reg[cand_idx] && active_reg[cand_idx];
    end

    assign fall      = prev_phase_reg && !blink_phase_reg;
    assign done_next = (fall && (best.done != DONE_MAX)) ? best.done + 8'd1 : best.done;

    always_comb
    begin
        wb_entry      = best;
        wb_entry.done = done_next;
    end

    assign mem_wr_en   = (accept && (req_type == REQ_WRITE) && in_range) ||
                         (state_reg == ST_COUNT);
    assign mem_wr_addr = (state_reg == ST_COUNT) ? best_idx : slot_idx;
    assign mem_wr_data = (state_reg == ST_COUNT) ? wb_entry : new_entry;

    psl_entry_mem #(
        .DEPTH (SLOTS),
        .AW    (SLOT_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (SLOT_W'(scan_cnt_reg)),
        .rd_data (mem_rd_data)
    );

    psl_picker #(
        .SLOT_W (SLOT_W)
    ) u_picker (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (pick_ctl),
        .cand     (mem_rd_data),
        .cand_idx (cand_idx),
        .found    (best_found),
        .best_idx (best_idx),
        .best     (best)
    );

    // a newly shown slot starts with the phase off
    assign phase0  = ({1'b0, best_idx} == last_shown_reg) ? blink_phase_reg : 1'b0;
    assign show_on = (best.period == 16'd0) || phase0;
    assign elapsed = ms_clock_reg - last_toggle_reg;
    assign toggle  = (best.period != 16'd0) && (elapsed > {16'd0, best.period});
    assign phase1  = phase0 ^ toggle;
    assign pins_next = show_on ? (best.color ^ {3{off_level_reg}}) : {3{off_level_reg}};

    assign out_free = !m_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            off_level_reg   <= 1'b0;
            valid_reg       <= '0;
            active_reg      <= '0;
            add_cnt_reg     <= '0;
            ms_clock_reg    <= '0;
            last_toggle_reg <= '0;
            blink_phase_reg <= 1'b0;
            prev_phase_reg  <= 1'b0;
            last_shown_reg  <= SLOT_NONE;
            scan_cnt_reg    <= '0;
            pins_reg        <= '0;
            shown_valid_reg <= 1'b0;
            shown_slot_reg  <= '0;
            m_valid_reg     <= 1'b0;
            m_data_reg      <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                off_level_reg <= cfg_wr_data;
            end

            // in ST_OUT the result register is reloaded below instead
            if (m_valid_reg && m_axis_tready && (state_reg != ST_OUT))
            begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= (req_type == REQ_TICK) ? ST_SCAN : ST_OUT;
                        case (req_type)
                            REQ_TICK:
                            begin
                                ms_clock_reg <= ms_clock_reg + 32'd1;
                                scan_cnt_reg <= '0;
                            end
                            REQ_WRITE:
                            begin
                                if (in_range)
                                begin
                                    valid_reg[slot_idx]  <= 1'b1;
                                    active_reg[slot_idx] <= s_axis_tdata[38];
                                    add_cnt_reg          <= add_cnt_reg + 32'd1;
                                    if (last_shown_reg == {1'b0, slot_idx})
                                    begin
                                        last_shown_reg <= SLOT_NONE;
                                    end
                                end
                            end
                            REQ_REMOVE:
                            begin
                                if (in_range)
                                begin
                                    valid_reg[slot_idx]  <= 1'b0;
                                    active_reg[slot_idx] <= 1'b0;
                                    if (last_shown_reg == {1'b0, slot_idx})
                                    begin
                                        last_shown_reg <= SLOT_NONE;
                                    end
                                end
                            end
                            default:
                            begin
                                if (in_range && valid_reg[slot_idx])
                                begin
                                    active_reg[slot_idx] <= s_axis_tdata[38];
                                end
                            end
                        endcase
                    end
                end
                ST_SCAN:
                begin
                    scan_cnt_reg <= scan_cnt_reg + CNT_W'(1);
                    if (scan_cnt_reg == SLOT_NONE)
                    begin
                        state_reg <= ST_APPLY;
                    end
                end
                ST_APPLY:
                begin
                    if (!best_found)
                    begin
                        pins_reg        <= '0;
                        shown_valid_reg <= 1'b0;
                        shown_slot_reg  <= '0;
                        state_reg       <= ST_OUT;
                    end
                    else
                    begin
                        pins_reg        <= pins_next;
                        shown_valid_reg <= 1'b1;
                        shown_slot_reg  <= 3'(best_idx);
                        last_shown_reg  <= {1'b0, best_idx};
                        blink_phase_reg <= phase1;
                        if (toggle)
                        begin
                            last_toggle_reg <= ms_clock_reg;
                        end
                        if ((best.period != 16'd0) && (best.limit != 8'd0))
                        begin
                            state_reg <= ST_COUNT;
                        end
                        else
                        begin
                            state_reg <= ST_OUT;
                        end
                    end
                end
                ST_COUNT:
                begin
                    prev_phase_reg <= blink_phase_reg;
                    if (done_next >= best.limit)
                    begin
                        active_reg[best_idx] <= 1'b0;
                    end
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {9'd0, shown_slot_reg, shown_valid_reg,
                                        pins_reg[0], pins_reg[1], pins_reg[2]};
                        state_reg   <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

>>> src/psl_checker.sv
module psl_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // nothing shown means zero pin levels and slot zero
    a_dark: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[3] |->
            (m_axis_tdata[2:0] == 3'd0) && (m_axis_tdata[6:4] == 3'd0))
        else $error("pins lit with no entry shown");

    // one request at a time: busy the cycle after a request is taken
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while busy");

    // unused bits of the result stay zero
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[15:7] == 9'd0))
        else $error("result padding not zero");

endmodule

bind priority_status_led_blinker psl_checker u_psl_checker (.*);

>>> tb/sv/priority_status_led_blinker_tb.sv
module priority_status_led_blinker_tb;

    import psl_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_OFF_CYCLES = 150;

    typedef struct packed {
        logic [2:0] slot;
        logic       shown;
        logic       blue;
        logic       green;
        logic       red;
    } pin_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic        cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [1:0]  s_axis_tuser;
    logic [39:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;

    // predicted copy of the status table and blink state
    logic [7:0]  tbl_prio   [LED_SLOTS];
    logic [2:0]  tbl_colour [LED_SLOTS];
    logic [15:0] tbl_period [LED_SLOTS];
    logic [7:0]  tbl_limit  [LED_SLOTS];
    logic [7:0]  tbl_blinks [LED_SLOTS];
    logic        tbl_valid  [LED_SLOTS];
    logic        tbl_active [LED_SLOTS];
    logic [31:0] tbl_stamp  [LED_SLOTS];
    logic [31:0] stamp_next;
    logic [31:0] ms_now;
    logic [31:0] toggle_at;
    logic        phase_on;
    logic        phase_prev;
    int          last_slot;
    logic        off_level;
    pin_result_t held_pins;

    pin_result_t pending_pins[$];

    int idle_pct;
    int stall_pct;
    int hold_requests;
    int hold_seen;
    int hold_left;
    int cycle_count;
    int mismatch_count;
    int requests_sent;
    int results_seen;

    priority_status_led_blinker i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // request word: kind in [1:0], the tdata fields from bit 2 up
    function automatic logic [47:0] pack_request(input req_t kind, input logic [2:0] slot,
                                                 input logic [7:0] prio,
                                                 input logic [2:0] colour,
                                                 input logic [15:0] period,
                                                 input logic [7:0] limit, input logic act);
        return {7'b0, act, limit, period, colour, prio, slot, kind};
    endfunction

    function automatic logic [47:0] random_request();
        int          pick;
        req_t        kind;
        logic [7:0]  prio;
        logic [15:0] period;
        logic [7:0]  limit;
        logic        act;
        pick = $urandom_range(99);
        kind = (pick < 45) ? REQ_TICK : (pick < 70) ? REQ_WRITE :
               (pick < 80) ? REQ_REMOVE : REQ_SET_ACTIVE;
        // few distinct priorities so that ties and recency matter
        prio = ($urandom_range(9) < 7) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
        pick = $urandom_range(9);
        period = (pick < 6) ? 16'($urandom_range(3)) :
                 (pick < 9) ? 16'($urandom_range(20)) : 16'($urandom_range(65535));
        pick = $urandom_range(9);
        limit = (pick < 4) ? 8'd0 :
                (pick < 9) ? 8'($urandom_range(4, 1)) : 8'($urandom_range(255));
        act = (kind == REQ_WRITE) ? ($urandom_range(9) != 0) : 1'($urandom_range(1));
        return pack_request(kind, 3'($urandom_range(7)), prio, 3'($urandom_range(7)),
                            period, limit, act);
    endfunction

    task automatic run_tick();
        int best;
        best = LED_SLOTS;
        ms_now = ms_now + 32'd1;
        for (int i = 0; i < LED_SLOTS; i++)
        begin
            if (tbl_valid[i] && tbl_active[i])
            begin
                if (best == LED_SLOTS || tbl_prio[i] > tbl_prio[best] ||
                    (tbl_prio[i] == tbl_prio[best] && tbl_stamp[i] > tbl_stamp[best]))
                    best = i;
            end
        end
        if (best == LED_SLOTS)
        begin
            held_pins = '0;
            return;
        end
        held_pins.shown = 1'b1;
        held_pins.slot  = best[2:0];
        if (best != last_slot)
            phase_on = 1'b0;
        last_slot = best;
        if (tbl_period[best] == 0 || phase_on)
        begin
            held_pins.red   = tbl_colour[best][2] ^ off_level;
            held_pins.green = tbl_colour[best][1] ^ off_level;
            held_pins.blue  = tbl_colour[best][0] ^ off_level;
        end
        else
        begin
            held_pins.red   = off_level;
            held_pins.green = off_level;
            held_pins.blue  = off_level;
        end
        if (tbl_period[best] == 0)
            return;
        if (ms_now - toggle_at > {16'd0, tbl_period[best]})
        begin
            toggle_at = ms_now;
            phase_on  = ~phase_on;
        end
        if (tbl_limit[best] == 0)
            return;
        // a blink is counted on the on-to-off edge
        if (phase_on != phase_prev && phase_prev && tbl_blinks[best] < DONE_MAX)
            tbl_blinks[best] = tbl_blinks[best] + 8'd1;
        phase_prev = phase_on;
        if (tbl_blinks[best] >= tbl_limit[best])
            tbl_active[best] = 1'b0;
    endtask

    task automatic advance_table(input logic [47:0] word);
        req_t kind;
        int   s;
        kind = req_t'(word[1:0]);
        s = word[4:2];
        case (kind)
            REQ_TICK:
                run_tick();
            REQ_WRITE:
            begin
                tbl_prio[s]   = word[12:5];
                tbl_colour[s] = word[15:13];
                tbl_period[s] = word[31:16];
                tbl_limit[s]  = word[39:32];
                tbl_blinks[s] = '0;
                tbl_valid[s]  = 1'b1;
                tbl_active[s] = word[40];
                tbl_stamp[s]  = stamp_next;
                stamp_next    = stamp_next + 32'd1;
                if (last_slot == s)
                    last_slot = LED_SLOTS;
            end
            REQ_REMOVE:
            begin
                tbl_valid[s]  = 1'b0;
                tbl_active[s] = 1'b0;
                if (last_slot == s)
                    last_slot = LED_SLOTS;
            end
            REQ_SET_ACTIVE:
                if (tbl_valid[s])
                    tbl_active[s] = word[40];
        endcase
        pending_pins.push_back(held_pins);
    endtask

    // called at a falling edge, returns at the falling edge after the handshake
    task automatic push_request(input logic [47:0] word);
        while ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= word[1:0];
        s_axis_tdata  <= {1'b0, word[40:2]};
        do
            @(posedge clk);
        while (!s_axis_tready);
        advance_table(word);
        requests_sent++;
        @(negedge clk);
    endtask

    task automatic send_tick();
        push_request(pack_request(REQ_TICK, 3'd0, 8'd0, 3'd0, 16'd0, 8'd0, 1'b0));
    endtask

    task automatic wait_idle();
        while (pending_pins.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_off_level(input logic level);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= level;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        off_level = level;
    endtask

    task automatic test_directed_entries();
        idle_pct  = 0;
        stall_pct = 0;
        write_off_level(1'b0);
        // empty table, then set-active on a slot never written
        send_tick();
        push_request(pack_request(REQ_SET_ACTIVE, 3'd3, 8'd0, 3'd0, 16'd0, 8'd0, 1'b1));
        send_tick();
        push_request(pack_request(REQ_WRITE, 3'd0, 8'd0, 3'd7, 16'd0, 8'd0, 1'b1));
        send_tick();
        // fast blinker with a one-blink limit, falls back to slot 0 when spent
        push_request(pack_request(REQ_WRITE, 3'd7, 8'd255, 3'd5, 16'd1, 8'd1, 1'b1));
        repeat (6) send_tick();
        push_request(pack_request(REQ_WRITE, 3'd4, 8'd255, 3'd2, 16'hFFFF, 8'd255, 1'b1));
        push_request(pack_request(REQ_WRITE, 3'd5, 8'd255, 3'd1, 16'd0, 8'd0, 1'b0));
        send_tick();
        // same priority: the newer entry wins once active
        push_request(pack_request(REQ_SET_ACTIVE, 3'd5, 8'hFF, 3'd7, 16'hFFFF, 8'hFF, 1'b1));
        send_tick();
        push_request(pack_request(REQ_SET_ACTIVE, 3'd5, 8'd0, 3'd0, 16'd0, 8'd0, 1'b0));
        send_tick();
        push_request(pack_request(REQ_REMOVE, 3'd4, 8'd0, 3'd0, 16'd0, 8'd0, 1'b0));
        push_request(pack_request(REQ_REMOVE, 3'd0, 8'd0, 3'd0, 16'd0, 8'd0, 1'b0));
        send_tick();
        s_axis_tvalid <= 1'b0;
        wait_idle();
    endtask

    task automatic test_random_mix(input int count, input int idle, input int stall,
                                   input logic level);
        idle_pct  = idle;
        stall_pct = stall;
        write_off_level(level);
        for (int i = 0; i < count; i++)
        begin
            push_request(random_request());
            // now and then the sender waits for the block to run dry
            if (i % 80 == 79)
            begin
                s_axis_tvalid <= 1'b0;
                wait_idle();
                @(negedge clk);
            end
        end
        s_axis_tvalid <= 1'b0;
        wait_idle();
    endtask

    task automatic test_output_holdoff();
        idle_pct  = 0;
        stall_pct = 0;
        write_off_level(1'b1);
        @(posedge clk);
        hold_requests++;
        @(negedge clk);
        for (int i = 0; i < 40; i++)
            push_request(random_request());
        s_axis_tvalid <= 1'b0;
        wait_idle();
    endtask

    // receiver: random stalls plus the occasional long hold-off
    initial
    begin
        m_axis_tready = 1'b0;
        hold_seen = 0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_seen != hold_requests)
            begin
                hold_seen = hold_requests;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        pin_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (pending_pins.size() == 0)
            begin
                $error("result 0x%0h arrived with no request outstanding", m_axis_tdata);
                mismatch_count++;
            end
            else
            begin
                want = pending_pins.pop_front();
                if (m_axis_tdata[0] !== want.red)
                begin
                    $error("red_level: expected %0d, got %0d", want.red, m_axis_tdata[0]);
                    mismatch_count++;
                end
                if (m_axis_tdata[1] !== want.green)
                begin
                    $error("green_level: expected %0d, got %0d", want.green, m_axis_tdata[1]);
                    mismatch_count++;
                end
                if (m_axis_tdata[2] !== want.blue)
                begin
                    $error("blue_level: expected %0d, got %0d", want.blue, m_axis_tdata[2]);
                    mismatch_count++;
                end
                if (m_axis_tdata[3] !== want.shown)
                begin
                    $error("shown_valid: expected %0d, got %0d", want.shown, m_axis_tdata[3]);
                    mismatch_count++;
                end
                if (m_axis_tdata[6:4] !== want.slot)
                begin
                    $error("shown_slot: expected %0d, got %0d", want.slot, m_axis_tdata[6:4]);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tuser   = '0;
        s_axis_tdata   = '0;
        idle_pct       = 0;
        stall_pct      = 0;
        hold_requests  = 0;
        mismatch_count = 0;
        requests_sent  = 0;
        results_seen   = 0;
        for (int i = 0; i < LED_SLOTS; i++)
        begin
            tbl_prio[i]   = '0;
            tbl_colour[i] = '0;
            tbl_period[i] = '0;
            tbl_limit[i]  = '0;
            tbl_blinks[i] = '0;
            tbl_valid[i]  = 1'b0;
            tbl_active[i] = 1'b0;
            tbl_stamp[i]  = '0;
        end
        stamp_next = '0;
        ms_now     = '0;
        toggle_at  = '0;
        phase_on   = 1'b0;
        phase_prev = 1'b0;
        last_slot  = LED_SLOTS;
        off_level  = 1'b0;
        held_pins  = '0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        test_directed_entries();
        test_random_mix(200, 0, 0, 1'b1);
        test_random_mix(150, 88, 0, 1'b0);
        test_random_mix(150, 0, 88, 1'b1);
        test_random_mix(100, 13, 13, 1'b0);
        test_output_holdoff();

        wait_idle();
        repeat (20) @(posedge clk);
        $display("Sent %0d requests, checked %0d results.", requests_sent, results_seen);
        $display("Directed table cases, four idle/stall mixes, a long output hold-off, "
                 , "both pin polarities.");
        if (mismatch_count == 0 && pending_pins.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> sim.f
src/psl_pkg.sv
src/psl_entry_mem.sv
src/psl_picker.sv
src/priority_status_led_blinker.sv
src/psl_checker.sv
tb/sv/priority_status_led_blinker_tb.sv
